FILE: rtl/core/fpd_pkg.sv
// shared types, constants and tables for the fisheye point distortion pipeline
package fpd_pkg;

	localparam int ATAN_STAGES = 24;
	localparam int ROOT_BITS = 32;
	localparam int QUOT_BITS = 32;
	localparam int CORD_W = 38;
	localparam int ANG_W = 33;
	localparam int NUM_W = 59;
	localparam int LATENCY = 2 + ROOT_BITS + ATAN_STAGES + 1 + 5 + QUOT_BITS + 7;
	localparam logic [31:0] R_TINY = 32'd2;
	localparam logic [30:0] Q_ONE = 31'h4000_0000;

	typedef enum logic [2:0] {
		REG_FOCAL_X    = 3'd0,
		REG_FOCAL_Y    = 3'd1,
		REG_CENTER_X   = 3'd2,
		REG_CENTER_Y   = 3'd3,
		REG_COEFF_K12  = 3'd4,
		REG_COEFF_K34  = 3'd5,
		REG_SKEW_ALPHA = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} xy_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        r;
		logic               tiny;
	} ctx_t;

	typedef struct packed {
		ctx_t               ctx;
		logic signed [31:0] p;
	} ctxp_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'd843314856;
			5'd1:  a = 32'd497837829;
			5'd2:  a = 32'd263043836;
			5'd3:  a = 32'd133525158;
			5'd4:  a = 32'd67021686;
			5'd5:  a = 32'd33543515;
			5'd6:  a = 32'd16775850;
			5'd7:  a = 32'd8388437;
			5'd8:  a = 32'd4194282;
			5'd9:  a = 32'd2097149;
			5'd10: a = 32'd1048575;
			5'd11: a = 32'd524287;
			5'd12: a = 32'd262143;
			5'd13: a = 32'd131071;
			5'd14: a = 32'd65535;
			5'd15: a = 32'd32767;
			5'd16: a = 32'd16383;
			5'd17: a = 32'd8191;
			5'd18: a = 32'd4095;
			5'd19: a = 32'd2047;
			5'd20: a = 32'd1023;
			5'd21: a = 32'd511;
			5'd22: a = 32'd255;
			5'd23: a = 32'd127;
			5'd24: a = 32'd63;
			5'd25: a = 32'd31;
			5'd26: a = 32'd15;
			5'd27: a = 32'd7;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] coef_q20(input logic [15:0] c);
		return $signed({{10{c[15]}}, c, 6'd0});
	endfunction

endpackage

FILE: rtl/core/fpd_sqrt.sv
// pipelined floor square root, one root bit per stage
module fpd_sqrt import fpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] in_rad,
	output logic        out_valid,
	output logic [31:0] out_root
);

	logic [63:0] rem_s  [0:ROOT_BITS];
	logic [31:0] root_s [0:ROOT_BITS];
	logic        v_s    [0:ROOT_BITS];

	assign rem_s[0]  = in_rad;
	assign root_s[0] = '0;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
		localparam int B = ROOT_BITS - 1 - k;
		logic [63:0] trial;
		logic        take;

		assign trial = ({32'd0, root_s[k]} << (B + 1)) | (64'd1 << (2 * B));
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (take) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= root_s[k] | (32'd1 << B);
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_BITS];
	assign out_root  = root_s[ROOT_BITS];

endmodule

FILE: rtl/core/fpd_div.sv
// pipelined restoring divider for theta over r, quotient clamped to one
module fpd_div import fpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [31:0]      in_den,
	output logic             out_valid,
	output logic [30:0]      out_q
);

	logic [63:0] rem_s [0:QUOT_BITS];
	logic [31:0] den_s [0:QUOT_BITS];
	logic [31:0] q_s   [0:QUOT_BITS];
	logic        ovf_s [0:QUOT_BITS];
	logic        v_s   [0:QUOT_BITS];

	assign rem_s[0] = 64'(in_num);
	assign den_s[0] = in_den;
	assign q_s[0]   = '0;
	assign ovf_s[0] = {5'd0, in_num[NUM_W-1:32]} >= in_den;
	assign v_s[0]   = in_valid;

	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
		localparam int B = QUOT_BITS - 1 - k;
		logic [63:0] sub;
		logic        take;

		assign sub  = {32'd0, den_s[k]} << B;
		assign take = rem_s[k] >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			ovf_s[k+1] <= ovf_s[k];
			if (take) begin
				rem_s[k+1] <= rem_s[k] - sub;
				q_s[k+1]   <= q_s[k] | (32'd1 << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				q_s[k+1]   <= q_s[k];
			end
		end
	end

	assign out_valid = v_s[QUOT_BITS];
	assign out_q = (ovf_s[QUOT_BITS] || q_s[QUOT_BITS] > {1'b0, Q_ONE}) ?
		Q_ONE : q_s[QUOT_BITS][30:0];

endmodule

FILE: rtl/core/fisheye_point_distort.sv
// top level of the fisheye point distortion pipeline
// Maps one normalized point (Q4.28) to a distorted pixel position (Q16.16)
// under the Kannala-Brandt fisheye model. A point may be started in every
// clock cycle; busy stays low. Each result appears as a single-cycle done
// strobe, in start order, and cannot be stalled. The pipeline is the 32-stage
// square root, the 24-stage arctangent CORDIC, the 32-stage divider and the
// multiplier stages around them. Configuration is always accepted (cfg_ready
// high) and must only be written while no point is in flight.
module fisheye_point_distort import fpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] norm_x,
	input  logic signed [31:0] norm_y,
	output logic               done,
	output logic signed [31:0] pixel_u,
	output logic signed [31:0] pixel_v,
	output logic               clipped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [31:0] coeff_k12_q, coeff_k34_q;
	logic signed [15:0] skew_alpha_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q    <= 32'd65536;
			focal_y_q    <= 32'd65536;
			center_x_q   <= '0;
			center_y_q   <= '0;
			coeff_k12_q  <= '0;
			coeff_k34_q  <= '0;
			skew_alpha_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X:    focal_x_q    <= cfg_data;
				REG_FOCAL_Y:    focal_y_q    <= cfg_data;
				REG_CENTER_X:   center_x_q   <= cfg_data;
				REG_CENTER_Y:   center_y_q   <= cfg_data;
				REG_COEFF_K12:  coeff_k12_q  <= cfg_data;
				REG_COEFF_K34:  coeff_k34_q  <= cfg_data;
				REG_SKEW_ALPHA: skew_alpha_q <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// squares and radius squared
	logic               v_s1, v_s2;
	xy_t                xy_s1, xy_s2;
	logic signed [63:0] xx_s1, yy_s1;
	logic [63:0]        rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		xy_s1.x <= norm_x;
		xy_s1.y <= norm_y;
		xx_s1   <= norm_x * norm_x;
		yy_s1   <= norm_y * norm_y;
		xy_s2   <= xy_s1;
		rad_s2  <= $unsigned(xx_s1) + $unsigned(yy_s1);
	end

	// radius
	logic        sq_valid;
	logic [31:0] sq_root;
	xy_t         xy_dly [0:ROOT_BITS-1];

	fpd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_rad    (rad_s2),
		.out_valid (sq_valid),
		.out_root  (sq_root)
	);

	always_ff @(posedge clk) begin
		xy_dly[0] <= xy_s2;
		for (int i = 1; i < ROOT_BITS; i++) begin
			xy_dly[i] <= xy_dly[i-1];
		end
	end

	// arctangent cordic
	logic signed [CORD_W-1:0] cx_s [0:ATAN_STAGES];
	logic signed [CORD_W-1:0] cy_s [0:ATAN_STAGES];
	logic signed [ANG_W-1:0]  cz_s [0:ATAN_STAGES];
	ctx_t                     cctx_s [0:ATAN_STAGES];
	logic                     cv_s [0:ATAN_STAGES];

	assign cx_s[0]        = CORD_W'(64'sd1 << 30);
	assign cy_s[0]        = $signed({4'd0, sq_root, 2'd0});
	assign cz_s[0]        = '0;
	assign cctx_s[0].x    = xy_dly[ROOT_BITS-1].x;
	assign cctx_s[0].y    = xy_dly[ROOT_BITS-1].y;
	assign cctx_s[0].r    = sq_root;
	assign cctx_s[0].tiny = sq_root <= R_TINY;
	assign cv_s[0]        = sq_valid;

	for (genvar i = 0; i < ATAN_STAGES; i++) begin : g_cordic
		logic signed [CORD_W-1:0] dx, dy;
		logic signed [ANG_W-1:0]  ang;

		assign dx  = cy_s[i] >>> i;
		assign dy  = cx_s[i] >>> i;
		assign ang = $signed({1'b0, atan_q30(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			cctx_s[i+1] <= cctx_s[i];
			if (!cy_s[i][CORD_W-1]) begin
				cx_s[i+1] <= cx_s[i] + dx;
				cy_s[i+1] <= cy_s[i] - dy;
				cz_s[i+1] <= cz_s[i] + ang;
			end else begin
				cx_s[i+1] <= cx_s[i] - dx;
				cy_s[i+1] <= cy_s[i] + dy;
				cz_s[i+1] <= cz_s[i] - ang;
			end
		end
	end

	// theta squared and polynomial
	logic                     v_st;
	logic signed [ANG_W-1:0]  th_st;
	logic signed [2*ANG_W-1:0] thsq_st;
	ctx_t                     ctx_st;

	logic                     v_h [1:5];
	logic signed [ANG_W-1:0]  th_h [1:5];
	ctx_t                     ctx_h [1:5];
	logic [31:0]              t2_h [1:3];
	logic signed [64:0]       prod_h [1:4];
	logic signed [31:0]       p_h5;
	logic signed [31:0]       kq [1:4];
	logic signed [31:0]       hsum [2:4];

	assign kq[1] = coef_q20(coeff_k12_q[15:0]);
	assign kq[2] = coef_q20(coeff_k12_q[31:16]);
	assign kq[3] = coef_q20(coeff_k34_q[15:0]);
	assign kq[4] = coef_q20(coeff_k34_q[31:16]);

	assign hsum[2] = kq[3] + $signed(prod_h[1][61:30]);
	assign hsum[3] = kq[2] + $signed(prod_h[2][61:30]);
	assign hsum[4] = kq[1] + $signed(prod_h[3][61:30]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_st <= 1'b0;
			for (int i = 1; i <= 5; i++) begin
				v_h[i] <= 1'b0;
			end
		end else begin
			v_st   <= cv_s[ATAN_STAGES];
			v_h[1] <= v_st;
			for (int i = 2; i <= 5; i++) begin
				v_h[i] <= v_h[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		th_st   <= cz_s[ATAN_STAGES];
		thsq_st <= cz_s[ATAN_STAGES] * cz_s[ATAN_STAGES];
		ctx_st  <= cctx_s[ATAN_STAGES];

		th_h[1]   <= th_st;
		ctx_h[1]  <= ctx_st;
		t2_h[1]   <= thsq_st[61:30];
		prod_h[1] <= kq[4] * $signed({1'b0, thsq_st[61:30]});
		for (int i = 2; i <= 5; i++) begin
			th_h[i]  <= th_h[i-1];
			ctx_h[i] <= ctx_h[i-1];
		end
		for (int i = 2; i <= 3; i++) begin
			t2_h[i] <= t2_h[i-1];
		end
		for (int i = 2; i <= 4; i++) begin
			prod_h[i] <= hsum[i] * $signed({1'b0, t2_h[i-1]});
		end
		p_h5 <= 32'sd1048576 + $signed(prod_h[4][61:30]);
	end

	// theta over r
	logic [NUM_W-1:0] div_num;
	logic             dv_valid;
	logic [30:0]      dv_q;
	ctxp_t            cp_dly [0:QUOT_BITS-1];

	assign div_num = (!th_h[5][ANG_W-1] && th_h[5] != '0) ?
		{th_h[5][30:0], 28'd0} : '0;

	fpd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_h[5]),
		.in_num    (div_num),
		.in_den    (ctx_h[5].r),
		.out_valid (dv_valid),
		.out_q     (dv_q)
	);

	always_ff @(posedge clk) begin
		cp_dly[0].ctx <= ctx_h[5];
		cp_dly[0].p   <= p_h5;
		for (int i = 1; i < QUOT_BITS; i++) begin
			cp_dly[i] <= cp_dly[i-1];
		end
	end

	// scale, skew, focal and centre
	logic               v_c, v_d, v_e, v_f, v_g, v_h2, v_i;
	logic signed [63:0] cdp_c;
	ctx_t               ctx_c;
	logic signed [37:0] cdist;
	logic signed [69:0] xprod, yprod;
	logic signed [39:0] xd_d, yd_d, xd_e, yd_e, yd_f;
	logic signed [55:0] ay_e;
	logic signed [42:0] xs_f, yde_f;
	logic [42:0]        mx_g, my_g;
	logic               sx_g, sy_g, sx_h, sy_h;
	logic [58:0]        ax_h, ay_h;
	logic [47:0]        bx_h, by_h;
	logic [59:0]        sumx, sumy;
	logic signed [49:0] fx_val, fy_val;
	logic [32:0]        satx, saty;
	logic signed [31:0] u_si, v_si;
	logic               clip_si;

	assign cdist = ctx_c.tiny ? 38'sd16777216 : $signed(cdp_c[63:26]);
	assign xprod = ctx_c.x * cdist;
	assign yprod = ctx_c.y * cdist;
	assign yde_f = 43'(yd_f);

	assign sumx = 60'(ax_h) + 60'(bx_h[47:16]);
	assign sumy = 60'(ay_h) + 60'(by_h[47:16]);
	assign fx_val = (sx_h ? -$signed({2'b00, sumx[59:12]}) : $signed({2'b00, sumx[59:12]}))
		+ $signed({18'd0, center_x_q});
	assign fy_val = (sy_h ? -$signed({2'b00, sumy[59:12]}) : $signed({2'b00, sumy[59:12]}))
		+ $signed({18'd0, center_y_q});

	function automatic logic [32:0] sat32(input logic signed [49:0] val);
		logic [32:0] res;
		if (val > 50'sh7FFF_FFFF) begin
			res = {1'b1, 32'h7FFF_FFFF};
		end else if (val < -50'sh8000_0000) begin
			res = {1'b1, 32'h8000_0000};
		end else begin
			res = {1'b0, val[31:0]};
		end
		return res;
	endfunction

	assign satx = sat32(fx_val);
	assign saty = sat32(fy_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c  <= 1'b0;
			v_d  <= 1'b0;
			v_e  <= 1'b0;
			v_f  <= 1'b0;
			v_g  <= 1'b0;
			v_h2 <= 1'b0;
			v_i  <= 1'b0;
		end else begin
			v_c  <= dv_valid;
			v_d  <= v_c;
			v_e  <= v_d;
			v_f  <= v_e;
			v_g  <= v_f;
			v_h2 <= v_g;
			v_i  <= v_h2;
		end
	end

	always_ff @(posedge clk) begin
		cdp_c <= $signed({1'b0, dv_q}) * cp_dly[QUOT_BITS-1].p;
		ctx_c <= cp_dly[QUOT_BITS-1].ctx;

		xd_d <= xprod[63:24];
		yd_d <= yprod[63:24];

		xd_e <= xd_d;
		yd_e <= yd_d;
		ay_e <= skew_alpha_q * yd_d;

		xs_f <= 43'(xd_e) + 43'($signed(ay_e[55:14]));
		yd_f <= yd_e;

		sx_g <= xs_f[42];
		mx_g <= xs_f[42] ? $unsigned(-xs_f) : $unsigned(xs_f);
		sy_g <= yde_f[42];
		my_g <= yde_f[42] ? $unsigned(-yde_f) : $unsigned(yde_f);

		sx_h <= sx_g;
		sy_h <= sy_g;
		ax_h <= mx_g[42:16] * focal_x_q;
		bx_h <= mx_g[15:0] * focal_x_q;
		ay_h <= my_g[42:16] * focal_y_q;
		by_h <= my_g[15:0] * focal_y_q;

		u_si    <= $signed(satx[31:0]);
		v_si    <= $signed(saty[31:0]);
		clip_si <= satx[32] | saty[32];
	end

	assign done    = v_i;
	assign pixel_u = u_si;
	assign pixel_v = v_si;
	assign clipped = clip_si;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching start");

	a_clip_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |-> (pixel_u == 32'sh7FFF_FFFF || pixel_u == -32'sh8000_0000 ||
			pixel_v == 32'sh7FFF_FFFF || pixel_v == -32'sh8000_0000))
		else $error("clipped set without a saturated coordinate");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == REG_FOCAL_X |=> focal_x_q == $past(cfg_data))
		else $error("focal_x write lost");

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the fisheye point distortion pipeline
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fpd_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 4000;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	typedef struct packed {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic               clip;
	} pixel_t;

	localparam longint ARCTAN_STEP [32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
		65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
		15, 7, 3, 1, 0, 0
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] norm_x = '0;
	logic signed [31:0] norm_y = '0;
	logic done;
	logic signed [31:0] pixel_u;
	logic signed [31:0] pixel_v;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [31:0] lens_fx = 32'd65536, lens_fy = 32'd65536;
	logic [31:0] lens_cx = '0, lens_cy = '0, lens_k12 = '0, lens_k34 = '0;
	logic [15:0] lens_alpha = '0;

	xy_t pending_points[$];
	pixel_t expected_pixels[$];
	bit steady_feed = 1'b0;
	int errors = 0, points_sent = 0, pixels_seen = 0, clip_count = 0, reg_writes = 0;
	int quiet_cycles = 0;

	fisheye_point_distort dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned int_root(longint unsigned val);
		longint unsigned res = 0, b = 64'd1 << 62;
		while (b > val) b >>= 2;
		while (b != 0) begin
			if (val >= res + b) begin
				val -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint arctan_q30(longint unsigned rad);
		longint cx = ONE_Q30, cy = longint'(rad) * 4, z = 0, dx, dy;
		for (int i = 0; i < ATAN_STAGES && i < 32; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx; cy -= dy; z += ARCTAN_STEP[i];
			end else begin
				cx -= dx; cy += dy; z -= ARCTAN_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic longint focal_scale(longint val, logic [31:0] f);
		longint unsigned m, a, b, mag, fw;
		fw = {32'd0, f};
		m = val < 0 ? longint'(-val) : val;
		a = (m >> 16) * fw;
		b = ((m & 64'hFFFF) * fw) >> 16;
		mag = (a + b) >> 12;
		return val < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic pixel_t distort_point(logic signed [31:0] nx, logic signed [31:0] ny);
		longint x, y, cd, th, t2, p, q, xd, yd, xs, uu, vv;
		longint k1, k2, k3, k4;
		longint unsigned rad;
		pixel_t res;
		x = nx;
		y = ny;
		rad = int_root(longint'(x * x) + longint'(y * y));
		cd = 64'sd1 << 24;
		if (rad > R_TINY) begin
			k1 = longint'($signed(lens_k12[15:0])) * 64;
			k2 = longint'($signed(lens_k12[31:16])) * 64;
			k3 = longint'($signed(lens_k34[15:0])) * 64;
			k4 = longint'($signed(lens_k34[31:16])) * 64;
			th = arctan_q30(rad);
			t2 = (th * th) >>> 30;
			p = k4;
			p = k3 + ((p * t2) >>> 30);
			p = k2 + ((p * t2) >>> 30);
			p = k1 + ((p * t2) >>> 30);
			p = (64'sd1 << 20) + ((p * t2) >>> 30);
			q = (th * (64'sd1 << 28)) / longint'(rad);
			if (q < 0) q = 0;
			if (q > ONE_Q30) q = ONE_Q30;
			cd = (q * p) >>> 26;
		end
		xd = (x * cd) >>> 24;
		yd = (y * cd) >>> 24;
		xs = xd + ((longint'($signed(lens_alpha)) * yd) >>> 14);
		uu = focal_scale(xs, lens_fx) + longint'({32'd0, lens_cx});
		vv = focal_scale(yd, lens_fy) + longint'({32'd0, lens_cy});
		res.clip = 1'b0;
		if (uu > 64'sd2147483647) begin uu = 64'sd2147483647; res.clip = 1'b1; end
		if (uu < -64'sd2147483648) begin uu = -64'sd2147483648; res.clip = 1'b1; end
		if (vv > 64'sd2147483647) begin vv = 64'sd2147483647; res.clip = 1'b1; end
		if (vv < -64'sd2147483648) begin vv = -64'sd2147483648; res.clip = 1'b1; end
		res.u = uu[31:0];
		res.v = vv[31:0];
		return res;
	endfunction

	// point feed
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_pixels.push_back(distort_point(norm_x, norm_y));
				points_sent++;
			end
			if (!start || !busy) begin
				if (pending_points.size() > 0 && (steady_feed || $urandom_range(99) >= 18)) begin
					start <= 1'b1;
					norm_x <= pending_points[0].x;
					norm_y <= pending_points[0].y;
					pending_points.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// pixel checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			pixel_t want;
			pixels_seen++;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel u=%h v=%h clipped=%b", $time, pixel_u, pixel_v,
					clipped);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (clipped) clip_count++;
				if (pixel_u !== want.u) begin
					$display("%0t: pixel_u expected %h actual %h", $time, want.u, pixel_u);
					errors++;
				end
				if (pixel_v !== want.v) begin
					$display("%0t: pixel_v expected %h actual %h", $time, want.v, pixel_v);
					errors++;
				end
				if (clipped !== want.clip) begin
					$display("%0t: clipped expected %b actual %b", $time, want.clip, clipped);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_FOCAL_X:    lens_fx = val;
			REG_FOCAL_Y:    lens_fy = val;
			REG_CENTER_X:   lens_cx = val;
			REG_CENTER_Y:   lens_cy = val;
			REG_COEFF_K12:  lens_k12 = val;
			REG_COEFF_K34:  lens_k34 = val;
			REG_SKEW_ALPHA: lens_alpha = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_lens(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx, logic [31:0] cy,
			logic [31:0] k12, logic [31:0] k34, logic [15:0] alpha);
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_COEFF_K12, k12);
		write_reg(REG_COEFF_K34, k34);
		write_reg(REG_SKEW_ALPHA, {16'd0, alpha});
	endtask

	task automatic add_point(logic [31:0] x, logic [31:0] y);
		xy_t pt;
		pt.x = x;
		pt.y = y;
		pending_points.push_back(pt);
	endtask

	function automatic logic [31:0] rand_coord();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(3))
			0: return w;
			1: return $signed(w) >>> $urandom_range(31);
			default: return $signed(w) >>> $urandom_range(4, 12);
		endcase
	endfunction

	task automatic drain();
		do @(posedge clk); while (pending_points.size() > 0 || start
			|| expected_pixels.size() > 0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero, tiny radius, extremes
		add_point(0, 0);
		add_point(1, 1);
		add_point(2, 0);
		add_point(32'hFFFF_FFFE, 0);
		add_point(3, 0);
		add_point(32'h1000_0000, 0);
		add_point(0, 32'hF000_0000);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'h8000_0000);
		add_point(32'h7FFF_FFFF, 32'h8000_0000);
		add_point(32'h8000_0000, 0);
		add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		steady_feed = 1'b1;
		drain();
		steady_feed = 1'b0;

		set_lens('1, '1, '1, '1, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 16'h7FFF);
		write_reg(REG_UNUSED, 32'h1234_5678);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'h8000_0000);
		add_point(32'h0100_0000, 32'hFF00_0000);
		add_point(2, 2);
		add_point(32'h1000_0000, 32'h1000_0000);
		drain();

		set_lens(0, 0, 0, 0, 32'h8000_8000, 32'h8000_8000, 16'h8000);
		add_point(32'h8000_0000, 32'h7FFF_FFFF);
		add_point(32'h1000_0000, 32'hF000_0000);
		add_point(32'h0400_0000, 32'h0400_0000);
		drain();

		set_lens(32'h0100_0000, 32'h0100_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_8000,
			32'h8000_8000, 16'h8000);
		add_point(32'h8000_0000, 32'h7FFF_FFFF);
		add_point(32'h1000_0000, 32'hF000_0000);
		add_point(0, 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				set_lens(32'd65536 * 640, 32'd65536 * 640, 32'd65536 * 960, 32'd65536 * 540,
					32'hFF80_0333, 32'h0010_FFE0, 16'd0);
			end else begin
				set_lens($urandom_range(1, 8) == 1 ? $urandom : $urandom_range(32'h1_0000,
					32'h400_0000), $urandom_range(1, 8) == 1 ? $urandom : $urandom_range(
					32'h1_0000, 32'h400_0000), $urandom, $urandom, $urandom, $urandom,
					16'($urandom));
			end
			steady_feed = (ph == 3);
			repeat (240) add_point(rand_coord(), rand_coord());
			drain();
		end

		repeat (LATENCY + 20) @(posedge clk);
		$display("covered %0d points over %0d register writes, %0d pixels, %0d clipped",
			points_sent, reg_writes, pixels_seen, clip_count);
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule

FILE: fisheye_point_distort.f
rtl/core/fpd_pkg.sv
rtl/core/fpd_sqrt.sv
rtl/core/fpd_div.sv
rtl/core/fisheye_point_distort.sv
tb/sv/testbench.sv
